>>> hdl/asm_pkg.sv
package asm_pkg;

  // Sample width clocked in by a read-sample operation (16 to 24).
  localparam int SAMPLE_BITS = 24;
  localparam int SAMPLE_W    = 24;

  // Input queue between the front end and the engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Operation codes.
  localparam logic [1:0] OP_READ_SAMPLE = 2'd0;
  localparam logic [1:0] OP_WRITE_CFG   = 2'd1;
  localparam logic [1:0] OP_READ_CFG    = 2'd2;
  localparam logic [1:0] OP_RESERVED    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_POLL_PERIOD = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;

  localparam logic [7:0]  HALF_RESET    = 8'd3;
  localparam logic [15:0] POLL_RESET    = 16'd1000;
  localparam logic [9:0]  TIMEOUT_RESET = 10'd300;

  typedef struct packed {
    logic [7:0]  half_period_ticks;
    logic [15:0] poll_period_ticks;
    logic [9:0]  timeout_polls;
  } cfg_t;

  // One classified input transaction.
  typedef struct packed {
    logic       tick;
    logic       start_ok;
    logic [1:0] opcode;
    logic [7:0] config_byte;
    logic       dout_level;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic                sclk_level;
    logic                data_drive_enable;
    logic                data_drive_value;
    logic                busy_res;
    logic                done_res;
    logic                timed_out;
    logic [SAMPLE_W-1:0] sample_value;
    logic [7:0]          config_value;
  } result_t;

endpackage

>>> hdl/asm_front.sv
module asm_front
  import asm_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       tick,
  input  logic       start_req,
  input  logic [1:0] opcode,
  input  logic [7:0] config_byte,
  input  logic       dout_level,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  // A start with the reserved opcode is dropped here, so the engine only
  // sees starts it must honour.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.tick        = tick;
    q_item.start_ok    = start_req && (opcode != OP_RESERVED);
    q_item.opcode      = opcode;
    q_item.config_byte = config_byte;
    q_item.dout_level  = dout_level;
  end

endmodule

>>> hdl/asm_queue.sv
module asm_queue
  import asm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head_item,
  output logic  full,
  output logic  empty
);

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/asm_engine.sv
module asm_engine
  import asm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PARKED = 3'd1;
  localparam logic [2:0] ST_POLL   = 3'd2;
  localparam logic [2:0] ST_HIGH   = 3'd3;
  localparam logic [2:0] ST_LOW    = 3'd4;

  localparam logic [5:0] FRAME_CLOCKS = 6'd46;
  localparam logic [5:0] RD_LOW_FIRST = 6'd27;
  localparam logic [5:0] RD_LOW_LAST  = 6'd28;
  localparam logic [5:0] CMD_FIRST    = 6'd29;
  localparam logic [5:0] CMD_LAST     = 6'd35;
  localparam logic [5:0] CMD_HOLD     = 6'd36;
  localparam logic [5:0] BYTE_FIRST   = 6'd37;
  localparam logic [5:0] BYTE_LAST    = 6'd44;
  localparam logic [6:0] WR_CMD       = 7'h65;
  localparam logic [6:0] RD_CMD       = 7'h56;

  logic [2:0]          state, state_next;
  logic [1:0]          active_op, active_op_next;
  logic [5:0]          clock_index, clock_index_next;
  logic [15:0]         tick_count, tick_count_next;
  logic [9:0]          poll_count, poll_count_next;
  logic [SAMPLE_W-1:0] shift_reg, shift_reg_next;
  logic [7:0]          tx_byte, tx_byte_next;
  logic                sclk_reg, sclk_reg_next;

  logic [15:0]         half_load;
  logic                samples_now;
  logic [SAMPLE_W-1:0] shifted;
  logic [SAMPLE_W-1:0] final_shift;
  logic [SAMPLE_W-1:0] sample_ext;
  logic [5:0]          index_inc;
  logic                done, tmo, drv_en, drv_val;
  logic [SAMPLE_W-1:0] sv;
  logic [7:0]          cv;
  logic [2:0]          cmd_bit, byte_bit;

  assign q_pop = !q_empty && (!out_valid || out_ready);

  assign half_load = (cfg.half_period_ticks == 8'd0) ? 16'd1 :
                     {8'd0, cfg.half_period_ticks};
  assign samples_now =
      ((active_op == OP_READ_SAMPLE) && (clock_index < 6'(SAMPLE_BITS))) ||
      ((active_op == OP_READ_CFG) && (clock_index >= BYTE_FIRST) &&
       (clock_index <= BYTE_LAST));
  assign shifted     = {shift_reg[SAMPLE_W-2:0], q_item.dout_level};
  assign final_shift = samples_now ? shifted : shift_reg;
  assign index_inc   = clock_index + 6'd1;

  // Sign extension of the final shift register value from SAMPLE_BITS to the
  // full sample width.
  always_comb begin
    for (int i = 0; i < SAMPLE_W; i++) begin
      sample_ext[i] = (i < SAMPLE_BITS) ? final_shift[i] : final_shift[SAMPLE_BITS-1];
    end
  end

  always_comb begin
    state_next       = state;
    active_op_next   = active_op;
    clock_index_next = clock_index;
    tick_count_next  = tick_count;
    poll_count_next  = poll_count;
    shift_reg_next   = shift_reg;
    tx_byte_next     = tx_byte;
    sclk_reg_next    = sclk_reg;
    done             = 1'b0;
    tmo              = 1'b0;
    sv               = '0;
    cv               = '0;
    unique case (state)
      ST_IDLE, ST_PARKED: begin
        if (q_item.start_ok) begin
          active_op_next   = q_item.opcode;
          tx_byte_next     = q_item.config_byte;
          shift_reg_next   = '0;
          poll_count_next  = '0;
          tick_count_next  = '0;
          clock_index_next = '0;
          sclk_reg_next    = 1'b0;
          state_next       = ST_POLL;
        end
      end
      ST_POLL: begin
        priority if (tick_count != 16'd0) begin
          if (q_item.tick) begin
            tick_count_next = tick_count - 16'd1;
          end
        end else if (!q_item.dout_level) begin
          clock_index_next = '0;
          tick_count_next  = half_load;
          sclk_reg_next    = 1'b1;
          state_next       = ST_HIGH;
        end else if (poll_count >= cfg.timeout_polls) begin
          poll_count_next = '0;
          sclk_reg_next   = 1'b1;
          state_next      = ST_PARKED;
          done            = 1'b1;
          tmo             = 1'b1;
        end else begin
          poll_count_next = poll_count + 10'd1;
          tick_count_next = cfg.poll_period_ticks;
        end
      end
      ST_HIGH: begin
        if (q_item.tick) begin
          if (tick_count <= 16'd1) begin
            sclk_reg_next   = 1'b0;
            tick_count_next = half_load;
            state_next      = ST_LOW;
          end else begin
            tick_count_next = tick_count - 16'd1;
          end
        end
      end
      ST_LOW: begin
        if (q_item.tick) begin
          if (tick_count <= 16'd1) begin
            if (samples_now) begin
              shift_reg_next = shifted;
            end
            if (index_inc >= FRAME_CLOCKS) begin
              done = 1'b1;
              if (active_op == OP_READ_SAMPLE) begin
                sv = sample_ext;
              end else if (active_op == OP_READ_CFG) begin
                cv = final_shift[7:0];
              end
              clock_index_next = '0;
              tick_count_next  = '0;
              sclk_reg_next    = 1'b0;
              state_next       = ST_IDLE;
            end else begin
              clock_index_next = index_inc;
              tick_count_next  = half_load;
              sclk_reg_next    = 1'b1;
              state_next       = ST_HIGH;
            end
          end else begin
            tick_count_next = tick_count - 16'd1;
          end
        end
      end
      default: begin
        state_next    = ST_IDLE;
        sclk_reg_next = 1'b0;
      end
    endcase
  end

  // Data pin use for the state after this step.
  assign cmd_bit  = 3'(CMD_LAST - clock_index_next);
  assign byte_bit = 3'(BYTE_LAST - clock_index_next);

  always_comb begin
    drv_en  = 1'b0;
    drv_val = 1'b0;
    if (state_next == ST_PARKED) begin
      drv_en  = 1'b1;
      drv_val = 1'b1;
    end else if ((state_next == ST_HIGH) || (state_next == ST_LOW)) begin
      if (active_op_next == OP_WRITE_CFG) begin
        priority if ((clock_index_next >= CMD_FIRST) &&
                     (clock_index_next <= CMD_LAST)) begin
          drv_en  = 1'b1;
          drv_val = WR_CMD[cmd_bit];
        end else if (clock_index_next == CMD_HOLD) begin
          drv_en  = 1'b1;
          drv_val = WR_CMD[0];
        end else if ((clock_index_next >= BYTE_FIRST) &&
                     (clock_index_next <= BYTE_LAST)) begin
          drv_en  = 1'b1;
          drv_val = tx_byte_next[byte_bit];
        end else if (clock_index_next > BYTE_LAST) begin
          drv_en  = 1'b1;
          drv_val = tx_byte_next[0];
        end else begin
          drv_en  = 1'b0;
        end
      end else if (active_op_next == OP_READ_CFG) begin
        priority if ((clock_index_next >= RD_LOW_FIRST) &&
                     (clock_index_next <= RD_LOW_LAST)) begin
          drv_en = 1'b1;
        end else if ((clock_index_next >= CMD_FIRST) &&
                     (clock_index_next <= CMD_LAST)) begin
          drv_en  = 1'b1;
          drv_val = RD_CMD[cmd_bit];
        end else begin
          drv_en = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active_op   <= OP_READ_SAMPLE;
      clock_index <= '0;
      tick_count  <= '0;
      poll_count  <= '0;
      shift_reg   <= '0;
      tx_byte     <= '0;
      sclk_reg    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        state       <= state_next;
        active_op   <= active_op_next;
        clock_index <= clock_index_next;
        tick_count  <= tick_count_next;
        poll_count  <= poll_count_next;
        shift_reg   <= shift_reg_next;
        tx_byte     <= tx_byte_next;
        sclk_reg    <= sclk_reg_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.sclk_level        <= sclk_reg_next;
      result.data_drive_enable <= drv_en;
      result.data_drive_value  <= drv_val;
      result.busy_res          <= (state_next == ST_POLL) || (state_next == ST_HIGH) ||
                                  (state_next == ST_LOW);
      result.done_res          <= done;
      result.timed_out         <= tmo;
      result.sample_value      <= sv;
      result.config_value      <= cv;
    end
  end

endmodule

>>> hdl/adc_two_wire_serial_master_unit.sv
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+--------------------------------------------
// input   | in        | in_valid / in_ready | tick, start_req, opcode, config_byte,
//         |           |                     | dout_level
// result  | out       | out_valid/out_ready | sclk_level, data_drive_enable,
//         |           |                     | data_drive_value, busy_res, done_res,
//         |           |                     | timed_out, sample_value, config_value
// config  | in        | cfg_we              | cfg_index, cfg_data
//
// One transaction is taken per clock while the queue has room; every input transaction
// gives exactly one result transaction, which passes through the queue and the engine's result register.
// The rate is set by the engine, which advances the interface state once per transaction.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// returns the engine to idle with the clock low and the data pin released.
// A stalled result holds the engine; the four-entry queue keeps accepting input
// until it fills, and in_ready falls only then.

module adc_two_wire_serial_master_unit
  import asm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                tick,
  input  logic                start_req,
  input  logic [1:0]          opcode,
  input  logic [7:0]          config_byte,
  input  logic                dout_level,
  // Result channel.
  output logic                out_valid,
  input  logic                out_ready,
  output logic                sclk_level,
  output logic                data_drive_enable,
  output logic                data_drive_value,
  output logic                busy_res,
  output logic                done_res,
  output logic                timed_out,
  output logic [SAMPLE_W-1:0] sample_value,
  output logic [7:0]          config_value,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  cfg_t    cfg;
  item_t   push_item;
  item_t   head_item;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  result_t result;

  // The engine reads the configuration registers directly, so a value written
  // during an operation takes effect at the next reload of the counter concerned.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_RESET;
      cfg.poll_period_ticks <= POLL_RESET;
      cfg.timeout_polls     <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data[7:0];
        REG_POLL_PERIOD: cfg.poll_period_ticks <= cfg_data;
        REG_TIMEOUT:     cfg.timeout_polls     <= cfg_data[9:0];
        default: begin
          // Writes to an unused index are ignored.
        end
      endcase
    end
  end

  // The front end classifies each transaction (a reserved opcode never starts
  // an operation) and pushes it into the queue.
  asm_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tick        (tick),
    .start_req   (start_req),
    .opcode      (opcode),
    .config_byte (config_byte),
    .dout_level  (dout_level),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  asm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The engine holds the polling and clocking state and the output register.
  asm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign sclk_level        = result.sclk_level;
  assign data_drive_enable = result.data_drive_enable;
  assign data_drive_value  = result.data_drive_value;
  assign busy_res          = result.busy_res;
  assign done_res          = result.done_res;
  assign timed_out         = result.timed_out;
  assign sample_value      = result.sample_value;
  assign config_value      = result.config_value;

endmodule

>>> hdl/asm_checker.sv
module asm_checker
  import asm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                sclk_level,
  input logic                data_drive_enable,
  input logic                data_drive_value,
  input logic                busy_res,
  input logic                done_res,
  input logic                timed_out,
  input logic [SAMPLE_W-1:0] sample_value,
  input logic [7:0]          config_value
);

  // A timeout is always reported together with done.
  a_timeout_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && timed_out) |-> done_res)
    else $error("timeout reported without done");

  // On a timeout both lines are parked high and driven, and the block is idle.
  a_timeout_parks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && timed_out) |->
      (sclk_level && data_drive_enable && data_drive_value && !busy_res))
    else $error("lines not parked high on timeout");

  // A completed frame leaves the clock low and the data pin released.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res && !timed_out) |->
      (!sclk_level && !data_drive_enable && !busy_res))
    else $error("frame did not end with clock low and pin released");

  // Data is only ever presented while driving, and results carry data only on done.
  a_quiet_lines: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |->
      ((data_drive_enable || !data_drive_value) && (sample_value == '0) &&
       (config_value == 8'd0)))
    else $error("stray data value outside an enabled drive or a done");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(sample_value) && $stable(done_res) && $stable(sclk_level)))
    else $error("result changed while stalled");

endmodule

bind adc_two_wire_serial_master_unit asm_checker u_asm_checker (.*);

>>> sim/tb_adc_two_wire_serial_master_unit.sv
`timescale 1ns / 1ps

// Testbench for the two-wire serial master. Every input transaction yields exactly one
// result transaction, so the bench keeps a queue of predicted pin levels, filled as each
// transaction is offered and drained by the result monitor in order.
module tb_adc_two_wire_serial_master_unit;
  import asm_pkg::*;

  localparam int CLK_PERIOD_NS     = 10;
  localparam int RUN_LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES     = 4;
  localparam int HOLD_OFF_CYCLES   = 200;
  localparam int MAX_REPORTS       = 10;
  localparam int FRAME_CLOCKS      = 46;
  localparam logic [7:0] WRITE_CMD = 8'h65;
  localparam logic [7:0] READ_CMD  = 8'h56;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - SAMPLE_BITS);

  typedef enum logic [2:0] {PH_IDLE, PH_PARKED, PH_POLL, PH_HIGH, PH_LOW} engine_phase_t;
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One input transaction as offered on the input channel.
  typedef struct packed {
    logic       tick;
    logic       start;
    logic [1:0] op;
    logic [7:0] cfg_byte;
    logic       dout;
  } link_item_t;

  // One line of the bring-up table: either a transaction or a register write.
  typedef struct {
    row_kind_t   kind;
    link_item_t  item;
    logic [1:0]  reg_index;
    logic [15:0] reg_value;
    bit          typed;
    result_t     want;
  } bringup_row_t;

  // Clock, reset and all block inputs start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                tick        = 1'b0;
  logic                start_req   = 1'b0;
  logic [1:0]          opcode      = OP_READ_SAMPLE;
  logic [7:0]          config_byte = 8'd0;
  logic                dout_level  = 1'b1;

  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic                sclk_level;
  logic                data_drive_enable;
  logic                data_drive_value;
  logic                busy_res;
  logic                done_res;
  logic                timed_out;
  logic [SAMPLE_W-1:0] sample_value;
  logic [7:0]          config_value;

  logic                cfg_we      = 1'b0;
  logic [1:0]          cfg_index   = REG_HALF_PERIOD;
  logic [15:0]         cfg_data    = 16'd0;

  // Predicted pin levels for transactions offered but not yet seen at the output.
  result_t pin_levels_due[$];
  int      mismatches   = 0;
  int      results_seen = 0;

  // Shared steering between the stimulus and the result sink.
  bit calm              = 1'b0;
  bit hold_off_request  = 1'b0;
  int tick_pct          = 90;

  // Our own copy of the engine and its registers.
  logic [7:0]          reg_half;
  logic [15:0]         reg_poll;
  logic [9:0]          reg_timeout;
  engine_phase_t       eng_phase;
  logic [1:0]          eng_op;
  int                  eng_clock;
  logic [15:0]         eng_ticks;
  logic [9:0]          eng_polls;
  logic [SAMPLE_W-1:0] eng_shift;
  logic [7:0]          eng_tx;
  logic                eng_sclk;

  bringup_row_t bringup_rows[$];

  always #(CLK_PERIOD_NS / 2) clk = ~clk;

  adc_two_wire_serial_master_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .tick             (tick),
    .start_req        (start_req),
    .opcode           (opcode),
    .config_byte      (config_byte),
    .dout_level       (dout_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sclk_level       (sclk_level),
    .data_drive_enable(data_drive_enable),
    .data_drive_value (data_drive_value),
    .busy_res         (busy_res),
    .done_res         (done_res),
    .timed_out        (timed_out),
    .sample_value     (sample_value),
    .config_value     (config_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // ---------------------------------------------------------------------------------------
  // Engine prediction.
  // ---------------------------------------------------------------------------------------

  function automatic void reset_engine();
    reg_half    = HALF_RESET;
    reg_poll    = POLL_RESET;
    reg_timeout = TIMEOUT_RESET;
    eng_phase   = PH_IDLE;
    eng_op      = OP_READ_SAMPLE;
    eng_clock   = 0;
    eng_ticks   = '0;
    eng_polls   = '0;
    eng_shift   = '0;
    eng_tx      = '0;
    eng_sclk    = 1'b0;
  endfunction

  function automatic bit engine_busy();
    return eng_phase == PH_POLL || eng_phase == PH_HIGH || eng_phase == PH_LOW;
  endfunction

  // Data-pin use inside a frame, decided by the operation and the clock number.
  function automatic void frame_pins(output logic en, output logic val);
    en  = 1'b0;
    val = 1'b0;
    if (eng_op == OP_WRITE_CFG) begin
      if (eng_clock >= 29 && eng_clock <= 35) begin
        en  = 1'b1;
        val = WRITE_CMD[35 - eng_clock];
      end else if (eng_clock == 36) begin
        en  = 1'b1;
        val = WRITE_CMD[0];
      end else if (eng_clock >= 37 && eng_clock <= 44) begin
        en  = 1'b1;
        val = eng_tx[44 - eng_clock];
      end else if (eng_clock >= 45) begin
        en  = 1'b1;
        val = eng_tx[0];
      end
    end else if (eng_op == OP_READ_CFG) begin
      if (eng_clock == 27 || eng_clock == 28) begin
        en = 1'b1;
      end else if (eng_clock >= 29 && eng_clock <= 35) begin
        en  = 1'b1;
        val = READ_CMD[35 - eng_clock];
      end
    end
  endfunction

  // Advances the engine copy by one input transaction and returns the pin levels and
  // status that the block should report for it.
  function automatic result_t predict_pins(input link_item_t it);
    result_t             r;
    logic [15:0]         half;
    logic [SAMPLE_W-1:0] sample;
    logic                en;
    logic                val;
    r    = '0;
    half = (reg_half == 8'd0) ? 16'd1 : {8'd0, reg_half};
    unique case (eng_phase)
      PH_IDLE, PH_PARKED: begin
        if (it.start && it.op != OP_RESERVED) begin
          eng_op    = it.op;
          eng_tx    = it.cfg_byte;
          eng_shift = '0;
          eng_polls = '0;
          eng_ticks = '0;
          eng_clock = 0;
          eng_sclk  = 1'b0;
          eng_phase = PH_POLL;
        end
      end
      PH_POLL: begin
        if (eng_ticks != 16'd0) begin
          if (it.tick) eng_ticks = eng_ticks - 16'd1;
        end else if (!it.dout) begin
          eng_clock = 0;
          eng_ticks = half;
          eng_sclk  = 1'b1;
          eng_phase = PH_HIGH;
        end else if (eng_polls >= reg_timeout) begin
          eng_polls   = '0;
          eng_sclk    = 1'b1;
          eng_phase   = PH_PARKED;
          r.done_res  = 1'b1;
          r.timed_out = 1'b1;
        end else begin
          eng_polls = eng_polls + 10'd1;
          eng_ticks = reg_poll;
        end
      end
      PH_HIGH: begin
        if (it.tick) begin
          if (eng_ticks <= 16'd1) begin
            eng_sclk  = 1'b0;
            eng_ticks = half;
            eng_phase = PH_LOW;
          end else begin
            eng_ticks = eng_ticks - 16'd1;
          end
        end
      end
      PH_LOW: begin
        if (it.tick) begin
          if (eng_ticks <= 16'd1) begin
            if ((eng_op == OP_READ_SAMPLE && eng_clock < SAMPLE_BITS) ||
                (eng_op == OP_READ_CFG && eng_clock >= 37 && eng_clock <= 44))
              eng_shift = {eng_shift[SAMPLE_W-2:0], it.dout};
            eng_clock = eng_clock + 1;
            if (eng_clock >= FRAME_CLOCKS) begin
              r.done_res = 1'b1;
              if (eng_op == OP_READ_SAMPLE) begin
                sample = eng_shift & SAMPLE_MASK;
                if (sample[SAMPLE_BITS-1]) sample = sample | ~SAMPLE_MASK;
                r.sample_value = sample;
              end else if (eng_op == OP_READ_CFG) begin
                r.config_value = eng_shift[7:0];
              end
              eng_clock = 0;
              eng_ticks = '0;
              eng_sclk  = 1'b0;
              eng_phase = PH_IDLE;
            end else begin
              eng_ticks = half;
              eng_sclk  = 1'b1;
              eng_phase = PH_HIGH;
            end
          end else begin
            eng_ticks = eng_ticks - 16'd1;
          end
        end
      end
      default: begin
        eng_phase = PH_IDLE;
        eng_sclk  = 1'b0;
      end
    endcase

    if (eng_phase == PH_PARKED) begin
      r.data_drive_enable = 1'b1;
      r.data_drive_value  = 1'b1;
    end else if (eng_phase == PH_HIGH || eng_phase == PH_LOW) begin
      frame_pins(en, val);
      r.data_drive_enable = en;
      r.data_drive_value  = val;
    end
    r.sclk_level = eng_sclk;
    r.busy_res   = engine_busy();
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------------------

  // Records the prediction first, then offers the transaction after a random gap and
  // holds it steady until the block takes it.
  task automatic offer_item(input link_item_t it, input result_t want);
    int gap;
    pin_levels_due.push_back(want);
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    tick        <= it.tick;
    start_req   <= it.start;
    opcode      <= it.op;
    config_byte <= it.cfg_byte;
    dout_level  <= it.dout;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every outstanding transaction has come back, then lets the block run on idle
  // so that nothing is still moving when a register changes.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The enable is lowered for a cycle between writes, so back-to-back writes never put two
  // assignments on it within one time step.
  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    unique case (idx)
      REG_HALF_PERIOD: reg_half    = value[7:0];
      REG_POLL_PERIOD: reg_poll    = value;
      REG_TIMEOUT:     reg_timeout = value[9:0];
      default: ;
    endcase
  endtask

  function automatic link_item_t random_item();
    link_item_t it;
    it.tick     = ($urandom_range(0, 99) < tick_pct);
    it.start    = 1'b0;
    it.op       = 2'($urandom_range(0, 3));
    it.cfg_byte = 8'($urandom_range(0, 255));
    it.dout     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Keeps feeding transactions until the engine is idle or parked again. The data pin
  // reads high on the first 'fails' polls and low after that; everywhere else it is
  // random, and stray start requests test that a busy engine ignores them.
  task automatic follow_through(input int fails);
    link_item_t it;
    int         left;
    left = fails;
    while (engine_busy()) begin
      it       = random_item();
      it.start = ($urandom_range(0, 15) == 0);
      if (eng_phase == PH_POLL && eng_ticks == 16'd0) begin
        it.dout = (left > 0);
        if (left > 0) left--;
      end
      offer_item(it, predict_pins(it));
    end
  endtask

  task automatic start_operation(input logic [1:0] op, input int fails);
    link_item_t it;
    it       = random_item();
    it.start = 1'b1;
    it.op    = op;
    offer_item(it, predict_pins(it));
    follow_through(fails);
  endtask

  // One random phase: program all three registers on an idle block, then run a number of
  // complete operations with a little idle noise in between. A negative force_fails lets
  // each operation draw its own count of failed polls.
  task automatic run_phase(input logic [7:0] half, input logic [15:0] poll,
                           input logic [9:0] tmo, input int n_ops, input int force_fails,
                           input int pct, input bit all_calm);
    link_item_t it;
    int         fails;
    int         limit;
    settle_block();
    write_register(REG_HALF_PERIOD, {8'd0, half});
    write_register(REG_POLL_PERIOD, poll);
    write_register(REG_TIMEOUT, {6'd0, tmo});
    tick_pct = pct;
    repeat (n_ops) begin
      calm = all_calm || ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 2)) begin
        it       = random_item();
        it.start = 1'($urandom_range(0, 1));
        if (it.start) it.op = OP_RESERVED;
        offer_item(it, predict_pins(it));
      end
      limit = (tmo < 3) ? tmo : 3;
      if (force_fails >= 0) fails = force_fails;
      else if (tmo <= 8 && $urandom_range(0, 4) == 0) fails = tmo + 1;
      else fails = $urandom_range(0, limit);
      start_operation(2'($urandom_range(0, 2)), fails);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Bring-up table helpers.
  // ---------------------------------------------------------------------------------------

  function automatic result_t levels(input int sclk, input int en, input int val,
                                     input int busy, input int done, input int tmo);
    result_t r;
    r = '0;
    r.sclk_level        = 1'(sclk);
    r.data_drive_enable = 1'(en);
    r.data_drive_value  = 1'(val);
    r.busy_res          = 1'(busy);
    r.done_res          = 1'(done);
    r.timed_out         = 1'(tmo);
    return r;
  endfunction

  function automatic void item_row(input logic tk, input logic st, input logic [1:0] op,
                                   input logic [7:0] cb, input logic dv, input bit typed,
                                   input result_t want);
    bringup_row_t row;
    row.kind      = ROW_ITEM;
    row.item      = '{tick: tk, start: st, op: op, cfg_byte: cb, dout: dv};
    row.reg_index = REG_HALF_PERIOD;
    row.reg_value = '0;
    row.typed     = typed;
    row.want      = want;
    bringup_rows.push_back(row);
  endfunction

  function automatic void reg_row(input logic [1:0] idx, input logic [15:0] value);
    bringup_row_t row;
    row.kind      = ROW_REG;
    row.item      = '0;
    row.reg_index = idx;
    row.reg_value = value;
    row.typed     = 1'b0;
    row.want      = '0;
    bringup_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result sink: a random stall before each result transaction, none while the stimulus
  // asks for a calm stretch, and one long hold-off on request so that the input queue
  // fills and the block has to push back on its input.
  // ---------------------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result monitor. Signals are read just after the rising edge, so they hold the values
  // that the edge itself saw; each accepted transaction is checked field by field
  // against the oldest prediction.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    bit      bad;
    if (!rst && out_valid && out_ready) begin
      got = result_t'{sclk_level, data_drive_enable, data_drive_value, busy_res,
                      done_res, timed_out, sample_value, config_value};
      if (pin_levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = pin_levels_due.pop_front();
        bad  = (got.sclk_level        !== want.sclk_level)        ||
               (got.data_drive_enable !== want.data_drive_enable) ||
               (got.data_drive_value  !== want.data_drive_value)  ||
               (got.busy_res          !== want.busy_res)          ||
               (got.done_res          !== want.done_res)          ||
               (got.timed_out         !== want.timed_out)         ||
               (got.sample_value      !== want.sample_value)      ||
               (got.config_value      !== want.config_value);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d expected sclk=%b en=%b val=%b busy=%b done=%b tmo=%b smp=%h cfg=%h",
                     results_seen, want.sclk_level, want.data_drive_enable,
                     want.data_drive_value, want.busy_res, want.done_res, want.timed_out,
                     want.sample_value, want.config_value);
            $display("result %0d actual   sclk=%b en=%b val=%b busy=%b done=%b tmo=%b smp=%h cfg=%h",
                     results_seen, got.sclk_level, got.data_drive_enable,
                     got.data_drive_value, got.busy_res, got.done_res, got.timed_out,
                     got.sample_value, got.config_value);
          end
        end
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    bringup_row_t row;
    result_t      pred;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    reset_engine();

    // Bring-up table. Expected levels are written out where they are obvious; the rest
    // fall back on the predictor.
    // Idle after reset: clock low, data released, nothing flagged.
    item_row(1'b0, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b0, 1'b1, levels(0, 0, 0, 0, 0, 0));
    // A start with the reserved opcode is ignored.
    item_row(1'b1, 1'b1, OP_RESERVED, 8'hFF, 1'b1, 1'b1, levels(0, 0, 0, 0, 0, 0));
    // Zero poll period, zero timeout limit and zero half period.
    reg_row(REG_POLL_PERIOD, 16'd0);
    reg_row(REG_TIMEOUT, 16'd0);
    reg_row(REG_HALF_PERIOD, 16'd0);
    item_row(1'b1, 1'b1, OP_READ_SAMPLE, 8'h00, 1'b1, 1'b1, levels(0, 0, 0, 1, 0, 0));
    // The first failed poll gives up at once; the start offered here is ignored as busy.
    item_row(1'b0, 1'b1, OP_WRITE_CFG, 8'hFF, 1'b1, 1'b1, levels(1, 1, 1, 0, 1, 1));
    // Parked with both lines driven high.
    item_row(1'b1, 1'b0, OP_READ_CFG, 8'h00, 1'b0, 1'b1, levels(1, 1, 1, 0, 0, 0));
    reg_row(REG_TIMEOUT, 16'd1);
    // Restart from the parked state; with a zero poll period the pin is polled every item.
    item_row(1'b0, 1'b1, OP_READ_CFG, 8'hFF, 1'b1, 1'b1, levels(0, 0, 0, 1, 0, 0));
    item_row(1'b1, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b1, 1'b1, levels(0, 0, 0, 1, 0, 0));
    item_row(1'b0, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b1, 1'b1, levels(1, 1, 1, 0, 1, 1));
    // Ready seen on the first poll: the frame opens with the clock high.
    item_row(1'b1, 1'b1, OP_WRITE_CFG, 8'hA5, 1'b1, 1'b1, levels(0, 0, 0, 1, 0, 0));
    item_row(1'b0, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b0, 1'b1, levels(1, 0, 0, 1, 0, 0));
    item_row(1'b1, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b1, 1'b1, levels(0, 0, 0, 1, 0, 0));
    item_row(1'b1, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b0, 1'b1, levels(1, 0, 0, 1, 0, 0));
    // A new half period written mid-frame takes effect at the next reload.
    reg_row(REG_HALF_PERIOD, 16'd2);
    item_row(1'b1, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b0, 1'b1, levels(0, 0, 0, 1, 0, 0));
    item_row(1'b1, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b1, 1'b0, '0);
    item_row(1'b1, 1'b0, OP_READ_SAMPLE, 8'h00, 1'b0, 1'b0, '0);

    foreach (bringup_rows[i]) begin
      row = bringup_rows[i];
      if (row.kind == ROW_REG) begin
        settle_block();
        write_register(row.reg_index, row.reg_value);
      end else begin
        pred = predict_pins(row.item);
        offer_item(row.item, row.typed ? row.want : pred);
      end
    end

    // Let the write-config frame left open by the table run to its end.
    tick_pct = 90;
    follow_through(0);

    // Random phases: complete operations with random content, from the shortest half
    // period to a zero poll period with a zero timeout limit. The long receiver hold-off
    // falls in the second one.
    run_phase(8'd1, 16'd3, 10'd4, 1, -1, 90, 1'b0);
    hold_off_request = 1'b1;
    run_phase(8'd1, 16'd3, 10'd4, 1, -1, 90, 1'b0);
    run_phase(8'd0, 16'd0, 10'd0, 2, -1, 100, 1'b0);

    in_valid <= 1'b0;
    while (pin_levels_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** adc_two_wire_serial_master_unit: PASSED **");
    end else begin
      $display("** adc_two_wire_serial_master_unit: FAILED **");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin : watchdog
    #(RUN_LIMIT_CYCLES * CLK_PERIOD_NS);
    $display("** adc_two_wire_serial_master_unit: FAILED **");
    $finish;
  end

endmodule
